FILE: hdl/assert_macros.svh
// assertion macros shared by the glob frame matcher modules
// expects clk and rst_n in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define GFM_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition must never be seen at a clock edge out of reset
`define GFM_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

FILE: hdl/gfm_pkg.sv
// shared types, constants and the star closure function of the glob frame matcher
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package gfm_pkg;

    localparam int PATTERN_CHARS = 32;
    localparam int IDX_W         = (PATTERN_CHARS > 1) ? $clog2(PATTERN_CHARS) : 1;
    localparam int LEN_W         = $clog2(PATTERN_CHARS + 1);
    localparam int VEC_W         = PATTERN_CHARS + 1;
    localparam int CLOSE_LEVELS  = $clog2(VEC_W);

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    localparam logic [7:0] STAR_CH   = 8'h2A;
    localparam logic [7:0] QUEST_CH  = 8'h3F;
    localparam logic [7:0] COLON_CH  = 8'h3A;
    localparam logic [7:0] DOLLAR_CH = 8'h24;

    localparam logic [LEN_W-1:0] PAT_LEN_MAX = LEN_W'(PATTERN_CHARS);

    typedef logic [7:0]               ch_t;
    typedef logic [VEC_W-1:0]         vec_t;
    typedef logic [PATTERN_CHARS-1:0] pmask_t;

    typedef enum logic
    {
        OP_PAT   = 1'b0,
        OP_FRAME = 1'b1
    } op_t;

    typedef struct packed
    {
        op_t  op;
        ch_t  ch;
        logic no_char;
        logic last;
        logic lead_skip;
    } cmd_t;

    // prefix j becomes active when some active prefix k <= j is followed only by stars
    // log-depth prefix network instead of a ripple over every position
    function automatic vec_t star_close(vec_t v, pmask_t star);
        vec_t g;
        vec_t p;
        vec_t g_n;
        vec_t p_n;
        int   d;
        g = v;
        p = '0;
        for (int j = 1; j < VEC_W; j++)
        begin
            p[j] = star[j-1];
        end
        for (int l = 0; l < CLOSE_LEVELS; l++)
        begin
            d   = 1 << l;
            g_n = g;
            p_n = '0;
            for (int j = 0; j < VEC_W; j++)
            begin
                if (j >= d)
                begin
                    g_n[j] = g[j] | (p[j] & g[j-d]);
                    p_n[j] = p[j] & p[j-d];
                end
            end
            g = g_n;
            p = p_n;
        end
        return g;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/gfm_item_if.sv
// input channel of the glob frame matcher: pattern and frame characters
// depends on nothing
`timescale 1ns / 1ps
`default_nettype none

interface gfm_item_if;
    logic       valid;
    logic       ready;
    logic       func;
    logic [7:0] ch;
    logic       no_char;
    logic       last;

    modport source (output valid, func, ch, no_char, last, input ready);
    modport sink   (input valid, func, ch, no_char, last, output ready);
endinterface

`default_nettype wire

FILE: hdl/gfm_result_if.sv
// result channel of the glob frame matcher: one verdict per frame
// depends on nothing
`timescale 1ns / 1ps
`default_nettype none

interface gfm_result_if;
    logic       valid;
    logic       ready;
    logic       proceed;
    logic [7:0] reply_code;

    modport source (output valid, proceed, reply_code, input ready);
    modport sink   (input valid, proceed, reply_code, output ready);
endinterface

`default_nettype wire

FILE: hdl/gfm_front.sv
// front stage: accepts input transactions, decodes them into commands
// depends on gfm_pkg and gfm_item_if
`timescale 1ns / 1ps
`default_nettype none

module gfm_front
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    gfm_item_if.sink           item,
    output gfm_pkg::cmd_t      cmd,
    output logic               cmd_valid,
    input  wire logic          cmd_ready
);

    logic          cmd_valid_reg;
    logic          cmd_valid_next;
    gfm_pkg::cmd_t cmd_reg;
    gfm_pkg::cmd_t cmd_next;
    logic          take;

    assign item.ready = !cmd_valid_reg || cmd_ready;
    assign take       = item.valid && item.ready;

    always_comb
    begin
        cmd_next.op        = item.func ? gfm_pkg::OP_FRAME : gfm_pkg::OP_PAT;
        cmd_next.ch        = item.ch;
        cmd_next.no_char   = item.no_char;
        cmd_next.last      = item.last;
        // leading frame marker, only honored on the first character of a frame
        cmd_next.lead_skip = (item.ch == gfm_pkg::COLON_CH) || (item.ch == gfm_pkg::DOLLAR_CH);
    end

    always_comb
    begin
        cmd_valid_next = cmd_valid_reg;
        if (take)
        begin
            cmd_valid_next = 1'b1;
        end
        else if (cmd_ready)
        begin
            cmd_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg <= 1'b0;
        end
        else
        begin
            cmd_valid_reg <= cmd_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            cmd_reg <= cmd_next;
        end
    end

    assign cmd       = cmd_reg;
    assign cmd_valid = cmd_valid_reg;

endmodule

`default_nettype wire

FILE: hdl/gfm_queue.sv
// short command queue between the front and the match engine
// depends on gfm_pkg and assert_macros.svh
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module gfm_queue
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire gfm_pkg::cmd_t in_cmd,
    input  wire logic          in_valid,
    output logic               in_ready,
    output gfm_pkg::cmd_t      out_cmd,
    output logic               out_valid,
    input  wire logic          out_ready
);

    gfm_pkg::cmd_t                   mem_reg [gfm_pkg::QUEUE_DEPTH];
    logic [gfm_pkg::QPTR_W-1:0]      wr_ptr_reg;
    logic [gfm_pkg::QPTR_W-1:0]      wr_ptr_next;
    logic [gfm_pkg::QPTR_W-1:0]      rd_ptr_reg;
    logic [gfm_pkg::QPTR_W-1:0]      rd_ptr_next;
    logic [gfm_pkg::QCNT_W-1:0]      count_reg;
    logic [gfm_pkg::QCNT_W-1:0]      count_next;
    logic                            push;
    logic                            pop;

    assign in_ready  = count_reg < gfm_pkg::QCNT_W'(gfm_pkg::QUEUE_DEPTH);
    assign out_valid = count_reg != '0;
    assign out_cmd   = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == gfm_pkg::QPTR_W'(gfm_pkg::QUEUE_DEPTH - 1))
                        ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == gfm_pkg::QPTR_W'(gfm_pkg::QUEUE_DEPTH - 1))
                        ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= in_cmd;
        end
    end

    `GFM_ASSERT(a_queue_count_up, push && !pop |=> count_reg == $past(count_reg) + 1'b1, "queue count did not grow on push")
    `GFM_NEVER(a_queue_overfill, count_reg > gfm_pkg::QCNT_W'(gfm_pkg::QUEUE_DEPTH), "queue holds more than its depth")

endmodule

`default_nettype wire

FILE: hdl/gfm_engine.sv
// match engine: pattern store, active prefix vector, one-shot arming and result register
// depends on gfm_pkg, gfm_result_if and assert_macros.svh
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module gfm_engine
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire gfm_pkg::cmd_t cmd,
    input  wire logic          cmd_valid,
    output logic               cmd_ready,
    input  wire logic [7:0]    error_code,
    gfm_result_if.source       result
);

    gfm_pkg::ch_t                store_reg [gfm_pkg::PATTERN_CHARS];
    logic [gfm_pkg::LEN_W-1:0]   len_reg;
    logic [gfm_pkg::LEN_W-1:0]   len_next;
    logic                        too_long_reg;
    logic                        too_long_next;
    logic                        armed_reg;
    logic                        armed_next;
    gfm_pkg::vec_t               act_reg;
    gfm_pkg::vec_t               act_next;
    logic                        frame_start_reg;
    logic                        frame_start_next;
    logic                        out_valid_reg;
    logic                        out_valid_next;
    logic                        out_proceed_reg;
    logic [7:0]                  out_code_reg;

    gfm_pkg::pmask_t             star_m;
    gfm_pkg::vec_t               start_vec;
    gfm_pkg::vec_t               vec0;
    gfm_pkg::vec_t               step_vec;
    gfm_pkg::vec_t               adv_vec;
    gfm_pkg::vec_t               vec1;
    logic [gfm_pkg::LEN_W-1:0]   len_base;
    logic                        too_long_base;
    logic                        skip;
    logic                        hit;
    logic                        is_result;
    logic                        cmd_pop;
    logic                        store_we;

    assign is_result = (cmd.op == gfm_pkg::OP_FRAME) && cmd.last;
    assign cmd_ready = !is_result || !out_valid_reg || result.ready;
    assign cmd_pop   = cmd_valid && cmd_ready;

    // stars inside the loaded pattern, one bit per store entry
    always_comb
    begin
        for (int i = 0; i < gfm_pkg::PATTERN_CHARS; i++)
        begin
            star_m[i] = (store_reg[i] == gfm_pkg::STAR_CH) && (i < int'(len_reg));
        end
    end

    assign start_vec = gfm_pkg::star_close(gfm_pkg::VEC_W'(1), star_m);
    assign vec0      = frame_start_reg ? start_vec : act_reg;

    // one character step: stars hold their prefix, literals and '?' move it forward
    always_comb
    begin
        step_vec = '0;
        for (int i = 0; i < gfm_pkg::PATTERN_CHARS; i++)
        begin
            if (vec0[i] && (i < int'(len_reg)))
            begin
                if (store_reg[i] == gfm_pkg::STAR_CH)
                begin
                    step_vec[i] = 1'b1;
                end
                else if ((store_reg[i] == gfm_pkg::QUEST_CH) || (store_reg[i] == cmd.ch))
                begin
                    step_vec[i+1] = 1'b1;
                end
            end
        end
    end

    assign adv_vec = gfm_pkg::star_close(step_vec, star_m);
    assign skip    = frame_start_reg && cmd.lead_skip;
    assign vec1    = (cmd.no_char || skip) ? vec0 : adv_vec;
    assign hit     = armed_reg && !too_long_reg && vec1[len_reg];

    // a pattern transaction after an armed pattern starts over
    assign len_base      = armed_reg ? '0 : len_reg;
    assign too_long_base = armed_reg ? 1'b0 : too_long_reg;
    assign store_we      = cmd_pop && (cmd.op == gfm_pkg::OP_PAT) && !cmd.no_char
                         && (len_base < gfm_pkg::PAT_LEN_MAX);

    always_comb
    begin
        len_next         = len_reg;
        too_long_next    = too_long_reg;
        armed_next       = armed_reg;
        act_next         = act_reg;
        frame_start_next = frame_start_reg;
        if (cmd_pop)
        begin
            unique case (cmd.op)
                gfm_pkg::OP_PAT:
                begin
                    len_next      = len_base;
                    too_long_next = too_long_base;
                    if (!cmd.no_char)
                    begin
                        if (len_base < gfm_pkg::PAT_LEN_MAX)
                        begin
                            len_next = len_base + 1'b1;
                        end
                        else
                        begin
                            too_long_next = 1'b1;
                        end
                    end
                    armed_next = cmd.last;
                end
                gfm_pkg::OP_FRAME:
                begin
                    act_next = vec1;
                    if (!cmd.no_char)
                    begin
                        frame_start_next = 1'b0;
                    end
                    if (cmd.last)
                    begin
                        frame_start_next = 1'b1;
                        if (hit)
                        begin
                            armed_next    = 1'b0;
                            len_next      = '0;
                            too_long_next = 1'b0;
                        end
                    end
                end
            endcase
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && !result.ready;
        if (cmd_pop && is_result)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg         <= '0;
            too_long_reg    <= 1'b0;
            armed_reg       <= 1'b0;
            act_reg         <= gfm_pkg::VEC_W'(1);
            frame_start_reg <= 1'b1;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            len_reg         <= len_next;
            too_long_reg    <= too_long_next;
            armed_reg       <= armed_next;
            act_reg         <= act_next;
            frame_start_reg <= frame_start_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (store_we)
        begin
            store_reg[len_base[gfm_pkg::IDX_W-1:0]] <= cmd.ch;
        end
        if (cmd_pop && is_result)
        begin
            out_proceed_reg <= !hit;
            out_code_reg    <= hit ? error_code : 8'd0;
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.proceed    = out_proceed_reg;
    assign result.reply_code = out_code_reg;

    `GFM_ASSERT(a_hit_disarms, cmd_pop && is_result && hit |=> !armed_reg && len_reg == '0, "match did not disarm the pattern")
    `GFM_ASSERT(a_overflow_full, too_long_reg |-> len_reg == gfm_pkg::PAT_LEN_MAX, "overflow flagged on a store that is not full")
    `GFM_ASSERT(a_armed_holds, armed_reg && !cmd_pop |=> armed_reg, "armed dropped without a command")

endmodule

`default_nettype wire

FILE: hdl/one_shot_glob_frame_matcher.sv
// One-shot glob frame matcher, top level.
// Channels: item (sink) takes pattern characters (func = 0) and command frame
// characters (func = 1); result (source) gives one verdict per frame, on the
// transaction that carries last = 1 with func = 1. Pattern transactions and
// non-final frame transactions give no result.
// Configuration: wr_en / wr_data write the 8-bit error code, no read-back.
// Path: a frame's final transaction goes through the front register, the queue
// and the result register. Throughput: one transaction per cycle, set by the
// active prefix vector update in the engine, unless result.ready stalls it.
// Stall: the result register holds while result.ready is low; pattern and
// non-final frame transactions keep flowing, and the next final frame
// transaction waits in the two-entry command queue behind the front register.
// Reset (rst_n low, asynchronous): no pattern armed, empty pattern, error
// code 0, the next frame character is treated as the start of a frame.
// Depends on gfm_pkg, the channel interfaces, gfm_front, gfm_queue, gfm_engine.
`timescale 1ns / 1ps
`default_nettype none

module one_shot_glob_frame_matcher
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    gfm_item_if.sink        item,
    gfm_result_if.source    result,
    input  wire logic       wr_en,
    input  wire logic [7:0] wr_data
);

    logic [7:0]    error_code_reg;
    logic [7:0]    error_code_next;
    gfm_pkg::cmd_t front_cmd;
    logic          front_valid;
    logic          front_ready;
    gfm_pkg::cmd_t q_cmd;
    logic          q_valid;
    logic          q_ready;

    assign error_code_next = wr_en ? wr_data : error_code_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            error_code_reg <= 8'd0;
        end
        else
        begin
            error_code_reg <= error_code_next;
        end
    end

    gfm_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .cmd       (front_cmd),
        .cmd_valid (front_valid),
        .cmd_ready (front_ready)
    );

    gfm_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_cmd    (front_cmd),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .out_cmd   (q_cmd),
        .out_valid (q_valid),
        .out_ready (q_ready)
    );

    gfm_engine u_engine
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (q_cmd),
        .cmd_valid  (q_valid),
        .cmd_ready  (q_ready),
        .error_code (error_code_reg),
        .result     (result)
    );

endmodule

`default_nettype wire
